/* hdl/scpd_pkg.sv */
// Shared types and constants for the servo command packet decoder.
// Used by every module of the block; no dependencies of its own.
package scpd_pkg;

    // Framing bytes and digit decoding
    localparam logic [7:0] START_BYTE  = 8'h2A;   // '*'
    localparam logic [7:0] END_BYTE    = 8'h23;   // '#'
    localparam logic [9:0] DIGIT_BASE  = 10'd48;  // '0'

    // Payload store geometry
    localparam int PAYLOAD_LEN   = 8;
    localparam int STORE_IDX_W   = $clog2(PAYLOAD_LEN);
    localparam int FILL_W        = $clog2(PAYLOAD_LEN + 1);
    localparam int DIGITS        = 4;
    localparam int STEP_W        = $clog2(DIGITS);

    // Arithmetic widths
    localparam int DIGIT_W       = 10;  // byte - 48, signed
    localparam int ACC_W         = 19;  // four-digit value, signed
    localparam int MAG_W         = ACC_W - 1;
    localparam int QUOT_W        = 15;  // |angle|, at most 22997
    localparam int GAIN_W        = 24;
    localparam int LIM_W         = 16;
    localparam int PROD_W        = QUOT_W + GAIN_W;
    localparam int TOTAL_W       = PROD_W + 3;
    localparam int PULSE_W       = TOTAL_W - 16;
    localparam int CMP_W         = 15;

    // Divide by ten: floor(m * ceil(2^22 / 10) / 2^22), exact for m < 2^18
    localparam int              DIV10_SHIFT = 22;
    localparam int              RECIP_W     = 19;
    localparam logic [RECIP_W-1:0] DIV10_RECIP = 19'd419431;

    // Reset values
    localparam logic [GAIN_W-1:0] PAN_GAIN_RST   = 24'd366637;
    localparam logic [LIM_W-1:0]  PAN_OFFSET_RST = 16'd893;
    localparam logic [LIM_W-1:0]  PAN_LOW_RST    = 16'd890;
    localparam logic [LIM_W-1:0]  PAN_HIGH_RST   = 16'd1905;
    localparam logic [GAIN_W-1:0] TILT_GAIN_RST  = 24'd706332;
    localparam logic [LIM_W-1:0]  TILT_OFFSET_RST = 16'd660;
    localparam logic [LIM_W-1:0]  TILT_LOW_RST   = 16'd655;
    localparam logic [LIM_W-1:0]  TILT_HIGH_RST  = 16'd1635;
    localparam logic [CMP_W-1:0]  PAN_CMP_RST    = 15'd675;
    localparam logic [CMP_W-1:0]  TILT_CMP_RST   = 15'd850;

    // Configuration register map
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAN_GAIN    = 3'd0,
        CFG_PAN_OFFSET  = 3'd1,
        CFG_PAN_LOW     = 3'd2,
        CFG_PAN_HIGH    = 3'd3,
        CFG_TILT_GAIN   = 3'd4,
        CFG_TILT_OFFSET = 3'd5,
        CFG_TILT_LOW    = 3'd6,
        CFG_TILT_HIGH   = 3'd7
    } t_cfg_idx;

    // Axis select
    localparam logic AXIS_PAN  = 1'b0;
    localparam logic AXIS_TILT = 1'b1;

    typedef struct packed {
        logic [GAIN_W-1:0] pan_gain;
        logic [LIM_W-1:0]  pan_offset;
        logic [LIM_W-1:0]  pan_low;
        logic [LIM_W-1:0]  pan_high;
        logic [GAIN_W-1:0] tilt_gain;
        logic [LIM_W-1:0]  tilt_offset;
        logic [LIM_W-1:0]  tilt_low;
        logic [LIM_W-1:0]  tilt_high;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic                   store_we;
        logic [STORE_IDX_W-1:0] store_idx;
        logic                   acc_en;
        logic                   acc_first;
        logic [STORE_IDX_W-1:0] digit_idx;
        logic                   div_en;
        logic                   mul_en;
        logic                   upd_en;
        logic                   axis;
        logic                   out_load;
        logic                   out_overrun;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_start;
        logic is_end;
        logic out_free;
    } t_dp_stat;

endpackage

/* hdl/scpd_cfg_regs.sv */
// Configuration register bank for the servo command packet decoder.
// Depends on scpd_pkg for the register map and reset values.
module scpd_cfg_regs
    import scpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GAIN_W-1:0]    i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // Writes are always taken
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register bank, 16-bit registers take the low 16 bits of the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pan_gain    <= PAN_GAIN_RST;
            r_cfg.pan_offset  <= PAN_OFFSET_RST;
            r_cfg.pan_low     <= PAN_LOW_RST;
            r_cfg.pan_high    <= PAN_HIGH_RST;
            r_cfg.tilt_gain   <= TILT_GAIN_RST;
            r_cfg.tilt_offset <= TILT_OFFSET_RST;
            r_cfg.tilt_low    <= TILT_LOW_RST;
            r_cfg.tilt_high   <= TILT_HIGH_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PAN_GAIN:    r_cfg.pan_gain    <= i_cfg_data;
                CFG_PAN_OFFSET:  r_cfg.pan_offset  <= i_cfg_data[LIM_W-1:0];
                CFG_PAN_LOW:     r_cfg.pan_low     <= i_cfg_data[LIM_W-1:0];
                CFG_PAN_HIGH:    r_cfg.pan_high    <= i_cfg_data[LIM_W-1:0];
                CFG_TILT_GAIN:   r_cfg.tilt_gain   <= i_cfg_data;
                CFG_TILT_OFFSET: r_cfg.tilt_offset <= i_cfg_data[LIM_W-1:0];
                CFG_TILT_LOW:    r_cfg.tilt_low    <= i_cfg_data[LIM_W-1:0];
                CFG_TILT_HIGH:   r_cfg.tilt_high   <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

/* hdl/scpd_ctrl.sv */
// Control state machine: packet framing, fill count and decode sequencing.
// Depends on scpd_pkg for the command and status structs.
module scpd_ctrl
    import scpd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_rx_valid,
    output logic     o_rx_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_DIV,
        S_MUL,
        S_UPD,
        S_PUT
    } t_state;

    t_state              r_state;
    logic                r_in_packet;
    logic [FILL_W-1:0]   r_fill;
    logic [STEP_W-1:0]   r_step;
    logic                r_axis;
    logic                r_overrun;
    logic                w_accept;
    logic                w_full;

    assign o_rx_ready = (r_state == S_IDLE);
    assign w_accept   = i_rx_valid && o_rx_ready;
    assign w_full     = (r_fill == FILL_W'(PAYLOAD_LEN));

    // Command decode
    always_comb begin
        o_cmd             = '0;
        o_cmd.store_we    = w_accept && r_in_packet && !i_stat.is_end && !w_full;
        o_cmd.store_idx   = r_fill[STORE_IDX_W-1:0];
        o_cmd.acc_en      = (r_state == S_ACC);
        o_cmd.acc_first   = (r_step == '0);
        o_cmd.digit_idx   = {r_axis, r_step};
        o_cmd.div_en      = (r_state == S_DIV);
        o_cmd.mul_en      = (r_state == S_MUL);
        o_cmd.upd_en      = (r_state == S_UPD);
        o_cmd.axis        = r_axis;
        o_cmd.out_load    = (r_state == S_PUT) && i_stat.out_free;
        o_cmd.out_overrun = r_overrun;
    end

    // State and framing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_packet <= 1'b0;
            r_fill      <= '0;
            r_step      <= '0;
            r_axis      <= AXIS_PAN;
            r_overrun   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (!r_in_packet) begin
                            if (i_stat.is_start) begin
                                r_in_packet <= 1'b1;
                                r_fill      <= '0;
                            end
                        end else if (i_stat.is_end) begin
                            r_in_packet <= 1'b0;
                            r_fill      <= '0;
                            r_overrun   <= 1'b0;
                            r_axis      <= AXIS_PAN;
                            r_step      <= '0;
                            r_state     <= S_ACC;
                        end else if (!w_full) begin
                            r_fill <= r_fill + 1'b1;
                        end else begin
                            r_in_packet <= 1'b0;
                            r_fill      <= '0;
                            r_overrun   <= 1'b1;
                            r_state     <= S_PUT;
                        end
                    end
                end
                S_ACC: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(DIGITS - 1)) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: r_state <= S_MUL;
                S_MUL: r_state <= S_UPD;
                S_UPD: begin
                    if (r_axis == AXIS_PAN) begin
                        r_axis  <= AXIS_TILT;
                        r_step  <= '0;
                        r_state <= S_ACC;
                    end else begin
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Checks
    a_fill_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_packet |-> (r_fill == '0))
        else $error("fill count not cleared outside a packet");

    a_store_in_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.store_we |-> (r_in_packet && !w_full))
        else $error("payload write outside a packet or past the store");

    a_decode_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_in_packet)
        else $error("decode running while a packet is open");

    a_put_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after result load");

endmodule

/* hdl/scpd_dp.sv */
// Datapath: payload store, digit accumulate, divide by ten, gain multiply,
// limit check, compare values and the result register. Uses scpd_pkg.
module scpd_dp
    import scpd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_rx_byte,
    input  t_cfg             i_cfg,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    input  logic             i_res_ready,
    output logic             o_res_valid,
    output logic             o_event_res,
    output logic             o_pan_accepted,
    output logic             o_tilt_accepted,
    output logic [CMP_W-1:0] o_pan_compare,
    output logic [CMP_W-1:0] o_tilt_compare
);

    logic [7:0]              r_store [PAYLOAD_LEN];
    logic signed [ACC_W-1:0] r_acc;
    logic [QUOT_W-1:0]       r_quot;
    logic                    r_neg;
    logic [PROD_W-1:0]       r_prod;
    logic [CMP_W-1:0]        r_pan_cmp;
    logic [CMP_W-1:0]        r_tilt_cmp;
    logic                    r_pan_ok;
    logic                    r_tilt_ok;
    logic                    r_out_valid;
    logic                    r_out_event;
    logic                    r_out_pan_ok;
    logic                    r_out_tilt_ok;
    logic [CMP_W-1:0]        r_out_pan_cmp;
    logic [CMP_W-1:0]        r_out_tilt_cmp;

    logic signed [DIGIT_W-1:0]     w_digit;
    logic signed [ACC_W-1:0]       w_digit_ext;
    logic signed [ACC_W-1:0]       w_acc_x10;
    logic [ACC_W-1:0]              w_abs;
    logic [MAG_W+RECIP_W-1:0]      w_qprod;
    logic [GAIN_W-1:0]             w_gain;
    logic [LIM_W-1:0]              w_offset;
    logic [LIM_W-1:0]              w_low;
    logic [LIM_W-1:0]              w_high;
    logic [TOTAL_W-1:0]            w_base;
    logic [TOTAL_W-1:0]            w_prod_ext;
    logic [TOTAL_W-1:0]            w_total;
    logic [PULSE_W-1:0]            w_pulse;
    logic                          w_in_range;

    // Status
    assign o_stat.is_start = (i_rx_byte == START_BYTE);
    assign o_stat.is_end   = (i_rx_byte == END_BYTE);
    assign o_stat.out_free = !r_out_valid || i_res_ready;

    // Payload store, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PAYLOAD_LEN; i++) begin
                r_store[i] <= '0;
            end
        end else if (i_cmd.store_we) begin
            r_store[i_cmd.store_idx] <= i_rx_byte;
        end
    end

    // Digit accumulate: acc = acc * 10 + (byte - 48)
    assign w_digit     = $signed({2'b00, r_store[i_cmd.digit_idx]}) - $signed(DIGIT_BASE);
    assign w_digit_ext = {{(ACC_W-DIGIT_W){w_digit[DIGIT_W-1]}}, w_digit};
    assign w_acc_x10   = (r_acc <<< 3) + (r_acc <<< 1);

    // Divide magnitude by ten via reciprocal, sign kept aside
    assign w_abs   = r_acc[ACC_W-1] ? (~r_acc + 1'b1) : r_acc;
    assign w_qprod = w_abs[MAG_W-1:0] * DIV10_RECIP;

    // Axis operand selection
    assign w_gain   = (i_cmd.axis == AXIS_TILT) ? i_cfg.tilt_gain   : i_cfg.pan_gain;
    assign w_offset = (i_cmd.axis == AXIS_TILT) ? i_cfg.tilt_offset : i_cfg.pan_offset;
    assign w_low    = (i_cmd.axis == AXIS_TILT) ? i_cfg.tilt_low    : i_cfg.pan_low;
    assign w_high   = (i_cmd.axis == AXIS_TILT) ? i_cfg.tilt_high   : i_cfg.pan_high;

    // Pulse = floor((offset << 16 +/- |angle| * gain) / 65536), top bit is sign
    assign w_base     = {{(TOTAL_W-LIM_W-16){1'b0}}, w_offset, 16'h0000};
    assign w_prod_ext = {{(TOTAL_W-PROD_W){1'b0}}, r_prod};
    assign w_total    = r_neg ? (w_base - w_prod_ext) : (w_base + w_prod_ext);
    assign w_pulse    = w_total[TOTAL_W-1:16];
    assign w_in_range = !w_total[TOTAL_W-1]
                     && (w_pulse >= {{(PULSE_W-LIM_W){1'b0}}, w_low})
                     && (w_pulse <= {{(PULSE_W-LIM_W){1'b0}}, w_high});

    // Arithmetic pipeline registers, one step per controller state
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_en) begin
            r_acc <= i_cmd.acc_first ? w_digit_ext : (w_acc_x10 + w_digit_ext);
        end
        if (i_cmd.div_en) begin
            r_quot <= w_qprod[DIV10_SHIFT +: QUOT_W];
            r_neg  <= r_acc[ACC_W-1];
        end
        if (i_cmd.mul_en) begin
            r_prod <= r_quot * w_gain;
        end
    end

    // Compare values and accept flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan_cmp  <= PAN_CMP_RST;
            r_tilt_cmp <= TILT_CMP_RST;
            r_pan_ok   <= 1'b0;
            r_tilt_ok  <= 1'b0;
        end else if (i_cmd.upd_en) begin
            if (i_cmd.axis == AXIS_PAN) begin
                r_pan_ok <= w_in_range;
                if (w_in_range) begin
                    r_pan_cmp <= w_pulse[CMP_W:1];
                end
            end else begin
                r_tilt_ok <= w_in_range;
                if (w_in_range) begin
                    r_tilt_cmp <= w_pulse[CMP_W:1];
                end
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_event    <= i_cmd.out_overrun;
            r_out_pan_ok   <= !i_cmd.out_overrun && r_pan_ok;
            r_out_tilt_ok  <= !i_cmd.out_overrun && r_tilt_ok;
            r_out_pan_cmp  <= r_pan_cmp;
            r_out_tilt_cmp <= r_tilt_cmp;
        end
    end

    assign o_res_valid     = r_out_valid;
    assign o_event_res     = r_out_event;
    assign o_pan_accepted  = r_out_pan_ok;
    assign o_tilt_accepted = r_out_tilt_ok;
    assign o_pan_compare   = r_out_pan_cmp;
    assign o_tilt_compare  = r_out_tilt_cmp;

    // Checks
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_res_ready))
        else $error("result register overwritten before it was taken");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("result not presented after load");

    a_overrun_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_event) |-> (!r_out_pan_ok && !r_out_tilt_ok))
        else $error("accept flag set on an overrun result");

endmodule

/* hdl/servo_command_packet_decoder_core.sv */
// Servo command packet decoder, top level.
// Channels: rx (one received byte per item), res (one result item per packet
// end or overrun) and a configuration write port with eight registers.
// A byte other than '#' inside a packet that is not an overrun, or any byte
// outside one, gives no result; the next byte is taken in the following cycle.
// '#' starts the decode: for pan and then tilt, 4 digit steps through the
// shared accumulator, a divide, a multiply and a limit check; then one result
// load. The rx channel is ready again in the cycle the result appears. An
// overrun byte, past a full payload store, goes straight to the result load.
// A result waits in its output register while the receiver stalls; bytes that
// give no result are still taken meanwhile, while a byte that gives a result
// holds the block until the register is free.
// Reset (synchronous, active low) restores register defaults, clears the
// payload store, returns to waiting for '*' and sets the compare values to
// 675 (pan) and 850 (tilt). Configuration writes are taken in any cycle.
// Depends on scpd_pkg, scpd_cfg_regs, scpd_ctrl and scpd_dp.
module servo_command_packet_decoder_core
    import scpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rx_valid,
    output logic                 o_rx_ready,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output logic                 o_event_res,
    output logic                 o_pan_accepted,
    output logic                 o_tilt_accepted,
    output logic [CMP_W-1:0]     o_pan_compare,
    output logic [CMP_W-1:0]     o_tilt_compare,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GAIN_W-1:0]    i_cfg_data
);

    t_cfg     w_cfg;
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Configuration registers
    scpd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Controller
    scpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Datapath
    scpd_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_byte       (i_rx_byte),
        .i_cfg           (w_cfg),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_res_ready     (i_res_ready),
        .o_res_valid     (o_res_valid),
        .o_event_res     (o_event_res),
        .o_pan_accepted  (o_pan_accepted),
        .o_tilt_accepted (o_tilt_accepted),
        .o_pan_compare   (o_pan_compare),
        .o_tilt_compare  (o_tilt_compare)
    );

endmodule
